/* hdl/multi_tap_gesture_detector_unit_assert.svh */
// Assertion macros used by the multi-tap detector checker file.
`ifndef MULTI_TAP_GESTURE_DETECTOR_UNIT_ASSERT_SVH
`define MULTI_TAP_GESTURE_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTGD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mtgd_pkg.sv */
// Types and constants of the multi-tap gesture detector.
package mtgd_pkg;

	// Result codes
	localparam logic [1:0] TRIG_NONE      = 2'd0;
	localparam logic [1:0] TRIG_ONGOING   = 2'd1;
	localparam logic [1:0] TRIG_TRIGGERED = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_TAP_WINDOW   = 2'd0;
	localparam logic [1:0] CFG_REPEAT_DELAY = 2'd1;
	localparam logic [1:0] CFG_TAPS_NEEDED  = 2'd2;

	// Configuration reset values
	localparam logic [23:0] TAP_WINDOW_RST   = 24'd200000;
	localparam logic [23:0] REPEAT_DELAY_RST = 24'd500000;
	localparam logic [3:0]  TAPS_NEEDED_RST  = 4'd2;

	typedef logic [1:0] trig_t;

	typedef struct packed {
		logic [23:0] tap_window_us;
		logic [23:0] repeat_delay_us;
		logic [3:0]  taps_needed;
	} cfg_t;

	typedef struct packed {
		logic [31:0] held_time;
		logic        was_active;
		logic [3:0]  taps_so_far;
		logic [31:0] gap_time;
	} state_t;

	typedef struct packed {
		logic        active;
		logic [19:0] delta_us;
		logic        press_seen;
		logic        release_seen;
		logic [63:0] first_press_time;
		logic [63:0] last_release_time;
	} item_t;

endpackage

/* hdl/mtgd_step.sv */
// Next-state and result logic for one frame of the multi-tap detector.
module mtgd_step (
	input  mtgd_pkg::cfg_t   cfg,
	input  mtgd_pkg::state_t cur,
	input  mtgd_pkg::item_t  item,
	output mtgd_pkg::state_t nxt,
	output mtgd_pkg::trig_t  result
);

	logic [32:0] held_sum;
	logic [31:0] held_new;
	logic [32:0] gap_sum;
	logic [31:0] gap_acc;
	logic        hold_drop;
	logic        gap_drop;
	logic [64:0] dur_diff;
	logic        short_dur;
	logic        in_frame_tap;
	logic        release_tap;
	logic [3:0]  taps_inc;

	// Saturating held time, cleared when inactive
	assign held_sum = {1'b0, cur.held_time} + {13'd0, item.delta_us};
	assign held_new = !item.active ? 32'd0 :
		(held_sum[32] ? 32'hFFFF_FFFF : held_sum[31:0]);

	// Gap time runs only while a sequence is open
	assign gap_sum = {1'b0, cur.gap_time} + {13'd0, item.delta_us};
	assign gap_acc = (cur.taps_so_far == 4'd0) ? cur.gap_time :
		(gap_sum[32] ? 32'hFFFF_FFFF : gap_sum[31:0]);

	assign hold_drop = held_new >= {8'd0, cfg.tap_window_us};
	assign gap_drop  = (cur.taps_so_far != 4'd0) && (gap_acc > {8'd0, cfg.repeat_delay_us});

	// In-frame duration; out-of-order stamps count as zero length
	assign dur_diff  = {1'b0, item.last_release_time} - {1'b0, item.first_press_time};
	assign short_dur = dur_diff[64] || (dur_diff[63:0] <= {40'd0, cfg.tap_window_us});

	assign in_frame_tap = item.press_seen && item.release_seen && !item.active && short_dur;
	assign release_tap  = cur.was_active && !item.active &&
		(cur.held_time < {8'd0, cfg.tap_window_us});
	assign taps_inc     = cur.taps_so_far + 4'd1;

	// Drops first, then taps, then the ongoing check
	always_comb begin
		nxt.held_time   = held_new;
		nxt.was_active  = item.active;
		nxt.taps_so_far = cur.taps_so_far;
		nxt.gap_time    = gap_acc;
		result          = mtgd_pkg::TRIG_NONE;
		priority if (hold_drop || gap_drop) begin
			nxt.taps_so_far = 4'd0;
			nxt.gap_time    = 32'd0;
		end else if (in_frame_tap || release_tap) begin
			nxt.gap_time = 32'd0;
			if (taps_inc >= cfg.taps_needed) begin
				nxt.taps_so_far = 4'd0;
				result          = mtgd_pkg::TRIG_TRIGGERED;
			end else begin
				nxt.taps_so_far = taps_inc;
				result          = mtgd_pkg::TRIG_ONGOING;
			end
		end else if ((cur.taps_so_far != 4'd0) || item.active) begin
			result = mtgd_pkg::TRIG_ONGOING;
		end else begin
			result = mtgd_pkg::TRIG_NONE;
		end
	end

endmodule

/* hdl/multi_tap_gesture_detector_unit.sv */
// Multi-tap gesture detector: one frame request in, one trigger state out per frame.
// Takes one frame request per clock while the output is not stalled and returns one result
// per request through the input and output registers. The frame lands in an input
// register, a single pass of saturating adds and compares (held time, gap time,
// a 64-bit timestamp difference) updates the tap state, and the trigger state is
// held in an output register until taken. Configuration writes take effect on the
// next frame and are expected only while no request is in flight.
module multi_tap_gesture_detector_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Frame request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        active,
	input  logic [19:0] delta_us,
	input  logic        press_seen,
	input  logic        release_seen,
	input  logic [63:0] first_press_time,
	input  logic [63:0] last_release_time,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  trigger_state,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	mtgd_pkg::cfg_t   cfg_q;
	mtgd_pkg::state_t state_q;
	mtgd_pkg::state_t state_nxt;
	mtgd_pkg::item_t  item_s1;
	mtgd_pkg::trig_t  result;
	mtgd_pkg::trig_t  trig_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             adv_s1;
	logic             in_acc;

	// Handshake: stage 1 moves on when the output register is free or being taken
	assign adv_s1    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign trigger_state = trig_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_window_us   <= mtgd_pkg::TAP_WINDOW_RST;
			cfg_q.repeat_delay_us <= mtgd_pkg::REPEAT_DELAY_RST;
			cfg_q.taps_needed     <= mtgd_pkg::TAPS_NEEDED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtgd_pkg::CFG_TAP_WINDOW:   cfg_q.tap_window_us   <= cfg_data;
				mtgd_pkg::CFG_REPEAT_DELAY: cfg_q.repeat_delay_us <= cfg_data;
				mtgd_pkg::CFG_TAPS_NEEDED:  cfg_q.taps_needed     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.active            <= active;
			item_s1.delta_us          <= delta_us;
			item_s1.press_seen        <= press_seen;
			item_s1.release_seen      <= release_seen;
			item_s1.first_press_time  <= first_press_time;
			item_s1.last_release_time <= last_release_time;
		end
	end

	mtgd_step u_step (
		.cfg    (cfg_q),
		.cur    (state_q),
		.item   (item_s1),
		.nxt    (state_nxt),
		.result (result)
	);

	// Tap state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			trig_q <= result;
		end
	end

endmodule

/* hdl/mtgd_checker.sv */
// Port-level checker for the multi-tap detector and its bind.
`include "multi_tap_gesture_detector_unit_assert.svh"

module mtgd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] trigger_state
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;
	logic       out_wait;
	logic       full_wait;
	logic       code_ok;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Conditions watched by the assertions
	assign out_wait  = out_valid && out_stall;
	assign full_wait = (pending_q == 2'd2) && !out_acc;
	assign code_ok   = (trigger_state == mtgd_pkg::TRIG_NONE) ||
		(trigger_state == mtgd_pkg::TRIG_ONGOING) ||
		(trigger_state == mtgd_pkg::TRIG_TRIGGERED);

	// Requests accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`MTGD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, out_valid && $stable(trigger_state), "stalled result moved")
	`MTGD_ASSERT_NOW(a_code_legal, clk, arst_n, out_valid, code_ok, "illegal trigger state")
	`MTGD_ASSERT_NOW(a_no_orphan, clk, arst_n, out_valid, pending_q != 2'd0, "result without request")
	`MTGD_ASSERT_NOW(a_depth, clk, arst_n, full_wait, !in_acc, "over two requests in flight")

endmodule

bind multi_tap_gesture_detector_unit mtgd_checker u_mtgd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.trigger_state (trigger_state)
);
